@@ rtl/core/tpdm_pkg.sv @@
// ----------------------------------------------------------------------------
// tpdm_pkg: shared definitions for the task preemption and deadline monitor
// Widths, operation codes, register indexes, event kinds and reset values.
// ----------------------------------------------------------------------------
package tpdm_pkg;

  localparam int TIME_BITS  = 48;
  localparam int COUNT_BITS = 32;

  localparam int GAP_THR_BITS = 16;
  localparam int LOG_THR_BITS = 24;
  localparam int PERIOD_BITS  = 24;
  localparam int BUDGET_BITS  = 24;
  localparam int TAG_BITS     = 16;
  localparam int VALUE_BITS   = 32;

  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 24;

  // Output payload: task, value, budget_done, three counters, three times.
  localparam int OUT_FIELD_BITS = TAG_BITS + VALUE_BITS + 1 + 3 * COUNT_BITS
                                  + 3 * TIME_BITS;
  localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;
  localparam int IN_DATA_BITS   = ((TIME_BITS + 7) / 8) * 8;

  typedef enum logic [1:0] {
    OP_ARM    = 2'd0,
    OP_START  = 2'd1,
    OP_SAMPLE = 2'd2,
    OP_END    = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_GAP_THR = 3'd0,
    REG_LOG_THR = 3'd1,
    REG_PERIOD  = 3'd2,
    REG_BUDGET  = 3'd3,
    REG_TAG     = 3'd4
  } reg_idx_t;

  localparam logic KIND_PREEMPT = 1'b0;
  localparam logic KIND_MISS    = 1'b1;

  localparam logic [GAP_THR_BITS-1:0] GAP_THR_RST = 16'd10;
  localparam logic [LOG_THR_BITS-1:0] LOG_THR_RST = 24'd10000;
  localparam logic [PERIOD_BITS-1:0]  PERIOD_RST  = 24'd5000;
  localparam logic [BUDGET_BITS-1:0]  BUDGET_RST  = 24'd1000;
  localparam logic [TAG_BITS-1:0]     TAG_RST     = 16'd0;

endpackage

@@ rtl/core/task_preemption_deadline_monitor_core.sv @@
// ----------------------------------------------------------------------------
// task_preemption_deadline_monitor_core: preemption and deadline monitor
// Follows one periodic task through timestamped requests and reports gaps,
// deadline misses and running statistics, one result per request.
// ----------------------------------------------------------------------------
// Pipeline: an accepted request moves from one input register to one result
//   register, and waits in the input register while the result is stalled.
// Throughput: one request per cycle while the result channel is not stalled; the
//   single pass over the state registers (48-bit subtracts feeding compares and the gap accumulator) sets it.
// Reset: rst_n low at a clock edge clears the valid bits of both pipeline stages,
//   all statistics and time state, and loads the register defaults.
module task_preemption_deadline_monitor_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // request channel
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [tpdm_pkg::IN_DATA_BITS-1:0]    in_tdata,  // [47:0] timestamp
  input  logic [1:0]                           in_tuser,  // [1:0] operation
  // result channel
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // [15:0] event_task, [47:16] event_value, [48] budget_done,
  // [80:49] gap_count, [128:81] gap_total, [176:129] gap_max,
  // [208:177] activation_count, [240:209] miss_count, [288:241] late_max,
  // [295:289] zero
  output logic [tpdm_pkg::OUT_DATA_BITS-1:0]   out_tdata,
  output logic [1:0]                           out_tuser, // [0] event_valid, [1] event_kind
  // configuration write channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [tpdm_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [tpdm_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  localparam int TB = tpdm_pkg::TIME_BITS;
  localparam int CB = tpdm_pkg::COUNT_BITS;

  // Configuration registers
  logic [tpdm_pkg::GAP_THR_BITS-1:0] gap_thr_r;
  logic [tpdm_pkg::LOG_THR_BITS-1:0] log_thr_r;
  logic [tpdm_pkg::PERIOD_BITS-1:0]  period_r;
  logic [tpdm_pkg::BUDGET_BITS-1:0]  budget_r;
  logic [tpdm_pkg::TAG_BITS-1:0]     tag_r;

  // Input stage
  logic               s1_valid_r, s1_valid_nxt;
  tpdm_pkg::op_t      s1_op_r;
  logic [TB-1:0]      s1_ts_r;

  // Monitor state
  logic [TB-1:0] last_sample_r, last_sample_nxt;
  logic [TB-1:0] budget_end_r,  budget_end_nxt;
  logic [TB-1:0] deadline_r,    deadline_nxt;
  logic [CB-1:0] preempt_cnt_r, preempt_cnt_nxt;
  logic [TB-1:0] preempt_tot_r, preempt_tot_nxt;
  logic [TB-1:0] preempt_max_r, preempt_max_nxt;
  logic [CB-1:0] act_cnt_r,     act_cnt_nxt;
  logic [CB-1:0] miss_cnt_r,    miss_cnt_nxt;
  logic [TB-1:0] late_max_r,    late_max_nxt;

  // Result register
  logic                                out_valid_r, out_valid_nxt;
  logic [tpdm_pkg::OUT_DATA_BITS-1:0]  out_data_r, out_data_nxt;
  logic [1:0]                          out_user_r, out_user_nxt;

  // Datapath terms
  logic                                 proc_go;
  logic [TB-1:0]                        gap, late;
  logic                                 win_open, gap_hit;
  logic                                 ev;
  logic                                 ev_kind;
  logic [tpdm_pkg::VALUE_BITS-1:0]      ev_value;
  logic                                 budget_done;

  // Advance the input stage whenever the result register is free or draining
  assign proc_go   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || proc_go;
  assign cfg_ready = 1'b1;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // Gap since the last sample and lateness against the deadline
  assign gap      = s1_ts_r - last_sample_r;
  assign late     = s1_ts_r - deadline_r;
  assign win_open = last_sample_r < budget_end_r;
  assign gap_hit  = win_open && (s1_ts_r > last_sample_r) && (gap > TB'(gap_thr_r));

  always_comb begin
    last_sample_nxt = last_sample_r;
    budget_end_nxt  = budget_end_r;
    deadline_nxt    = deadline_r;
    preempt_cnt_nxt = preempt_cnt_r;
    preempt_tot_nxt = preempt_tot_r;
    preempt_max_nxt = preempt_max_r;
    act_cnt_nxt     = act_cnt_r;
    miss_cnt_nxt    = miss_cnt_r;
    late_max_nxt    = late_max_r;
    ev              = 1'b0;
    ev_kind         = tpdm_pkg::KIND_PREEMPT;
    ev_value        = '0;
    unique case (s1_op_r)
      tpdm_pkg::OP_ARM: begin
        deadline_nxt = s1_ts_r + TB'(period_r);
      end
      tpdm_pkg::OP_START: begin
        last_sample_nxt = s1_ts_r;
        budget_end_nxt  = s1_ts_r + TB'(budget_r);
      end
      tpdm_pkg::OP_SAMPLE: begin
        // A closed window leaves everything as it is
        if (win_open) begin
          last_sample_nxt = s1_ts_r;
        end
        if (gap_hit) begin
          preempt_cnt_nxt = preempt_cnt_r + CB'(1);
          preempt_tot_nxt = preempt_tot_r + gap;
          if (gap > preempt_max_r) begin
            preempt_max_nxt = gap;
          end
          if (gap > TB'(log_thr_r)) begin
            ev       = 1'b1;
            ev_kind  = tpdm_pkg::KIND_PREEMPT;
            ev_value = gap[tpdm_pkg::VALUE_BITS-1:0];
          end
        end
      end
      tpdm_pkg::OP_END: begin
        act_cnt_nxt  = act_cnt_r + CB'(1);
        deadline_nxt = deadline_r + TB'(period_r);
        if (s1_ts_r > deadline_r) begin
          miss_cnt_nxt = miss_cnt_r + CB'(1);
          if (late > late_max_r) begin
            late_max_nxt = late;
          end
          ev       = 1'b1;
          ev_kind  = tpdm_pkg::KIND_MISS;
          ev_value = late[tpdm_pkg::VALUE_BITS-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  assign budget_done = last_sample_nxt >= budget_end_nxt;

  // Pack the result; event fields read zero when no event is raised
  always_comb begin
    out_data_nxt = '0;
    out_data_nxt[tpdm_pkg::OUT_FIELD_BITS-1:0] = {
      late_max_nxt, miss_cnt_nxt, act_cnt_nxt, preempt_max_nxt, preempt_tot_nxt,
      preempt_cnt_nxt, budget_done, ev_value, (ev ? tag_r : tpdm_pkg::TAG_BITS'(0))
    };
    out_user_nxt = {ev && ev_kind, ev};
  end

  always_comb begin
    if (in_tvalid && in_tready) begin
      s1_valid_nxt = 1'b1;
    end else if (proc_go) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
    if (proc_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control and monitor state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      last_sample_r <= '0;
      budget_end_r  <= '0;
      deadline_r    <= '0;
      preempt_cnt_r <= '0;
      preempt_tot_r <= '0;
      preempt_max_r <= '0;
      act_cnt_r     <= '0;
      miss_cnt_r    <= '0;
      late_max_r    <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (proc_go) begin
        last_sample_r <= last_sample_nxt;
        budget_end_r  <= budget_end_nxt;
        deadline_r    <= deadline_nxt;
        preempt_cnt_r <= preempt_cnt_nxt;
        preempt_tot_r <= preempt_tot_nxt;
        preempt_max_r <= preempt_max_nxt;
        act_cnt_r     <= act_cnt_nxt;
        miss_cnt_r    <= miss_cnt_nxt;
        late_max_r    <= late_max_nxt;
      end
    end
  end

  // Configuration registers: drop writes to unknown indexes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_thr_r <= tpdm_pkg::GAP_THR_RST;
      log_thr_r <= tpdm_pkg::LOG_THR_RST;
      period_r  <= tpdm_pkg::PERIOD_RST;
      budget_r  <= tpdm_pkg::BUDGET_RST;
      tag_r     <= tpdm_pkg::TAG_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tpdm_pkg::REG_GAP_THR: gap_thr_r <= cfg_data[tpdm_pkg::GAP_THR_BITS-1:0];
        tpdm_pkg::REG_LOG_THR: log_thr_r <= cfg_data[tpdm_pkg::LOG_THR_BITS-1:0];
        tpdm_pkg::REG_PERIOD:  period_r  <= cfg_data[tpdm_pkg::PERIOD_BITS-1:0];
        tpdm_pkg::REG_BUDGET:  budget_r  <= cfg_data[tpdm_pkg::BUDGET_BITS-1:0];
        tpdm_pkg::REG_TAG:     tag_r     <= cfg_data[tpdm_pkg::TAG_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // Payload registers: hold while not advancing
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_op_r <= tpdm_pkg::op_t'(in_tuser);
      s1_ts_r <= in_tdata[TB-1:0];
    end
    if (proc_go) begin
      out_data_r <= out_data_nxt;
      out_user_r <= out_user_nxt;
    end
  end

endmodule

@@ rtl/core/tpdm_checker.sv @@
// ----------------------------------------------------------------------------
// tpdm_checker: port-level checks for the monitor core
// Watches the result and configuration channels over time.
// ----------------------------------------------------------------------------
module tpdm_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                out_tvalid,
  input logic                                out_tready,
  input logic [tpdm_pkg::OUT_DATA_BITS-1:0]  out_tdata,
  input logic [1:0]                          out_tuser,
  input logic                                cfg_valid,
  input logic                                cfg_ready
);

  // A stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // Reset empties the result register
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // Without an event the event fields read zero
  a_no_event_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata[47:0] == 48'd0 && !out_tuser[1])
    else $error("event fields set without event");

  // Configuration writes are never stalled
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration write stalled");

endmodule

bind task_preemption_deadline_monitor_core tpdm_checker u_tpdm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .cfg_valid  (cfg_valid),
  .cfg_ready  (cfg_ready)
);
